[hw/rtl/assert_macros.svh]
// Assertion macros used by the top level of the escape counter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Condition must hold on every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

`endif

[hw/rtl/mbe_pkg.sv]
// Shared types and constants of the escape counter.
package mbe_pkg;

   localparam int ITER_BITS     = 12;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   // Register reset values, Q4.28 at the default coordinate width
   localparam logic signed [31:0]    X_MIN_RST    = -32'sd536870912;
   localparam logic signed [31:0]    Y_MIN_RST    = -32'sd300647711;
   localparam logic [31:0]           STEP_X_RST   = 32'd648129;
   localparam logic [31:0]           STEP_Y_RST   = 32'd587777;
   localparam logic [ITER_BITS-1:0]  MAX_ITER_RST = 12'd100;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_X_MIN    = 3'd0,
      CSR_Y_MIN    = 3'd1,
      CSR_STEP_X   = 3'd2,
      CSR_STEP_Y   = 3'd3,
      CSR_MAX_ITER = 3'd4
   } csr_reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COORD,
      ST_MUL,
      ST_STEP,
      ST_DONE
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;   // latch the pixel indices of an accepted request
      logic init;      // form c, clear z and the iteration count
      logic mult;      // register the three products of z
      logic step;      // advance z by one iteration
      logic emit;      // load the result register
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic finish;    // point escaped or iteration limit reached
   } stat_type;

endpackage

[hw/rtl/mbe_ctrl.sv]
// Controller state machine of the escape counter.
module mbe_ctrl import mbe_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   output logic     rsp_tvalid,
   input  logic     rsp_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   // Result register can take a new result this cycle
   assign slot_free = !rsp_valid_ff || rsp_tready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_tvalid) state_in = ST_COORD;
         ST_COORD: state_in = ST_MUL;
         ST_MUL:   state_in = ST_STEP;
         ST_STEP:  state_in = stat.finish ? ST_DONE : ST_MUL;
         ST_DONE:  if (slot_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Outputs and commands
   always_comb begin
      req_tready  = 1'b0;
      cmd         = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         ST_COORD: cmd.init = 1'b1;
         ST_MUL:   cmd.mult = 1'b1;
         ST_STEP:  cmd.step = !stat.finish;
         ST_DONE:  cmd.emit = slot_free;
         default:  cmd      = '0;
      endcase
   end

   // Hold the result valid until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[hw/rtl/mbe_dp.sv]
// Datapath of the escape counter: registers, coordinate, iteration and result.
module mbe_dp import mbe_pkg::*; #(
   parameter int INDEX_BITS = 14,
   parameter int COORD_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output stat_type                 stat,
   input  logic [INDEX_BITS-1:0]    req_col,
   input  logic [INDEX_BITS-1:0]    req_row,
   input  logic                     csr_write,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   output logic [ITER_BITS-1:0]     rsp_count,
   output logic [INDEX_BITS-1:0]    rsp_col,
   output logic [INDEX_BITS-1:0]    rsp_row
);

   localparam int C = COORD_BITS;
   localparam int F = COORD_BITS - 4;   // fraction bits
   localparam int W = COORD_BITS + 6;   // headroom for the update sums
   localparam int P = 2 * COORD_BITS;   // exact product width
   localparam logic [P:0] ESC_THR = (P+1)'(1) << (2 * F + 2);

   // Configuration registers
   logic signed [C-1:0]    x_min_ff, y_min_ff;
   logic [C-2:0]           step_x_ff, step_y_ff;
   logic [ITER_BITS-1:0]   max_iter_ff;

   // Working registers
   logic [INDEX_BITS-1:0]  col_ff, row_ff;
   logic signed [C-1:0]    cr_ff, ci_ff, cr_in, ci_in;
   logic signed [C-1:0]    zr_ff, zi_ff, zr_in, zi_in;
   logic [P-1:0]           sr_ff, si_ff, pc_ff;
   logic [ITER_BITS-1:0]   iter_ff;
   logic [ITER_BITS-1:0]   out_count_ff;
   logic [INDEX_BITS-1:0]  out_col_ff, out_row_ff;

   logic [INDEX_BITS+C-2:0] px, py;
   logic [C-1:0]           ar, ai;
   logic signed [W-1:0]    r2_w, i2_w, cm_w, cross_w, re_sum, im_sum;
   logic                   rem;
   logic [P:0]             mag_sq;

   // Clamp a wide sum to the coordinate range
   function automatic logic signed [C-1:0] sat_c(input logic signed [W-1:0] v);
      logic fits;
      fits = (&v[W-1:C-1]) || !(|v[W-1:C-1]);
      if (fits) begin
         return v[C-1:0];
      end
      return v[W-1] ? {1'b1, {(C-1){1'b0}}} : {1'b0, {(C-1){1'b1}}};
   endfunction

   // Widen a pixel index to the coordinate product width
   function automatic logic [INDEX_BITS+C-2:0] req_col_ext(input logic [INDEX_BITS-1:0] v);
      return (INDEX_BITS+C-1)'(v);
   endfunction

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         x_min_ff    <= C'(X_MIN_RST);
         y_min_ff    <= C'(Y_MIN_RST);
         step_x_ff   <= (C-1)'(STEP_X_RST);
         step_y_ff   <= (C-1)'(STEP_Y_RST);
         max_iter_ff <= MAX_ITER_RST;
      end else if (csr_write) begin
         unique case (csr_reg_type'(csr_addr))
            CSR_X_MIN:    x_min_ff    <= C'(signed'(csr_wdata));
            CSR_Y_MIN:    y_min_ff    <= C'(signed'(csr_wdata));
            CSR_STEP_X:   step_x_ff   <= (C-1)'(csr_wdata);
            CSR_STEP_Y:   step_y_ff   <= (C-1)'(csr_wdata);
            CSR_MAX_ITER: max_iter_ff <= csr_wdata[ITER_BITS-1:0];
            default:      ;
         endcase
      end
   end

   // Pixel to complex point, wrapping
   assign px    = req_col_ext(col_ff) * step_x_ff;
   assign py    = req_col_ext(row_ff) * step_y_ff;
   assign cr_in = x_min_ff + px[C-1:0];
   assign ci_in = y_min_ff + py[C-1:0];

   // Magnitudes of z for the shared products
   assign ar = zr_ff[C-1] ? C'(0) - zr_ff : zr_ff;
   assign ai = zi_ff[C-1] ? C'(0) - zi_ff : zi_ff;

   // Escape test on the exact squares of the current z, or iteration limit reached
   assign mag_sq      = {1'b0, sr_ff} + {1'b0, si_ff};
   assign stat.finish = ((iter_ff != '0) && (mag_sq > ESC_THR)) || (iter_ff == max_iter_ff);

   // One iteration: floor-shifted squares and cross term, then clamp
   always_comb begin
      r2_w    = W'(sr_ff >> F);
      i2_w    = W'(si_ff >> F);
      cm_w    = W'(pc_ff >> (F - 1));
      rem     = |pc_ff[F-2:0];
      cross_w = (zr_ff[C-1] ^ zi_ff[C-1]) ? -(cm_w + W'(rem)) : cm_w;
      re_sum  = r2_w - i2_w + W'(cr_ff);
      im_sum  = cross_w + W'(ci_ff);
      zr_in   = sat_c(re_sum);
      zi_in   = sat_c(im_sum);
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         col_ff <= req_col;
         row_ff <= req_row;
      end
      if (cmd.init) begin
         cr_ff   <= cr_in;
         ci_ff   <= ci_in;
         zr_ff   <= '0;
         zi_ff   <= '0;
         iter_ff <= '0;
      end
      if (cmd.mult) begin
         sr_ff <= P'(ar) * P'(ar);
         si_ff <= P'(ai) * P'(ai);
         pc_ff <= P'(ar) * P'(ai);
      end
      if (cmd.step) begin
         zr_ff   <= zr_in;
         zi_ff   <= zi_in;
         iter_ff <= ITER_BITS'(iter_ff + 1'b1);
      end
      if (cmd.emit) begin
         out_count_ff <= iter_ff;
         out_col_ff   <= col_ff;
         out_row_ff   <= row_ff;
      end
   end

   assign rsp_count = out_count_ff;
   assign rsp_col   = out_col_ff;
   assign rsp_row   = out_row_ff;

endmodule

[hw/rtl/mandelbrot_escape_count.sv]
// Top level of the Mandelbrot escape-time counter.
//
// Usage:
//   req channel carries one pixel (column and row index) per request. The
//   block maps it to c = (x_min + col*step_x, y_min + row*step_y), iterates
//   z = z^2 + c from zero and returns on the rsp channel the first iteration
//   at which |z|^2 > 4, or max_iter, with the pixel indices echoed.
//   csr channel writes the five registers by index; it is always ready and
//   must only be used while no request is in flight.
// Sequence:
//   One request is worked at a time: a new request is taken only after the
//   last result is loaded into the output register. Each iteration first
//   registers the three products of z, then tests and advances z.
// Reset clears the controller and loads the register defaults; no clearing
// pass is needed. A stalled receiver holds the result in the output
// register; the next request is still accepted and worked, and its result
// waits until the register frees.
`include "assert_macros.svh"

module mandelbrot_escape_count import mbe_pkg::*; #(
   parameter int  INDEX_BITS = 14,
   parameter int  COORD_BITS = 32,
   localparam int REQ_BITS   = ((2 * INDEX_BITS + 7) / 8) * 8,
   localparam int RSP_BITS   = ((ITER_BITS + 2 * INDEX_BITS + 7) / 8) * 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_BITS-1:0]      req_tdata,   // col_index, row_index
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_BITS-1:0]      rsp_tdata,   // escape_count, col_out, row_out
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   cmd_type                cmd;
   stat_type               stat;
   logic [ITER_BITS-1:0]   rsp_count;
   logic [INDEX_BITS-1:0]  rsp_col, rsp_row;
   logic                   req_fire;
   logic                   rsp_slot_free;

   assign csr_ready = 1'b1;

   mbe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   mbe_dp #(
      .INDEX_BITS (INDEX_BITS),
      .COORD_BITS (COORD_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_col   (req_tdata[INDEX_BITS-1:0]),
      .req_row   (req_tdata[2*INDEX_BITS-1:INDEX_BITS]),
      .csr_write (csr_valid && csr_ready),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .rsp_count (rsp_count),
      .rsp_col   (rsp_col),
      .rsp_row   (rsp_row)
   );

   // Pack the result, zero fill to whole bytes
   assign rsp_tdata = RSP_BITS'({rsp_row, rsp_col, rsp_count});

   // Handshake terms for the checks
   assign req_fire      = req_tvalid && req_tready;
   assign rsp_slot_free = !rsp_tvalid || rsp_tready;

   // Checks
   `ASSERT_NEXT(a_busy_after_req, clock, reset, req_fire, !req_tready, "request while busy")
   `ASSERT_IMPLY(a_emit_slot_free, clock, reset, cmd.emit, rsp_slot_free, "result overwritten")
   `ASSERT_ALWAYS(a_cmd_onehot, clock, reset, $onehot0(cmd), "conflicting datapath commands")
   `ASSERT_NEXT(a_emit_sets_valid, clock, reset, cmd.emit, rsp_tvalid, "result not presented")

endmodule
